/* sv/sol_packet_ack_tracker_top_assert.svh */
// Assertion macros used by the serial-over-LAN ack tracker port checker.
`ifndef SOL_PACKET_ACK_TRACKER_TOP_ASSERT_SVH
`define SOL_PACKET_ACK_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOL_ACK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sol_ack assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOL_ACK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sol_ack assertion failed");

`endif

/* sv/sol_ack_pkg.sv */
// Package with the command codes, status bits, sequence limits and header size of the ack tracker.
package sol_ack_pkg;

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_RECV  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam int unsigned ST_DATA_BIT   = 0;
    localparam int unsigned ST_RETRY_BIT  = 1;
    localparam int unsigned ST_UNUSED_BIT = 2;
    localparam int unsigned ST_BREAK_BIT  = 3;

    localparam logic [3:0] SEQ_NONE  = 4'd0;
    localparam logic [3:0] SEQ_FIRST = 4'd1;
    localparam logic [3:0] SEQ_TOP   = 4'd15;

    localparam logic [7:0] HDR_BYTES = 8'd4;

endpackage

/* sv/sol_ack_req_if.sv */
// Request channel carrying one send, receive-header or reset command.
interface sol_ack_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] send_count;
    logic [7:0] recv_length;
    logic [3:0] recv_seq;
    logic [3:0] ack_seq;
    logic [7:0] accepted_count;
    logic       nack_flag;
    logic       unavailable_flag;
    logic       inactive_flag;
    logic       overrun_flag;
    logic       break_flag;

    modport source (
        output valid, command, send_count, recv_length, recv_seq, ack_seq,
               accepted_count, nack_flag, unavailable_flag, inactive_flag,
               overrun_flag, break_flag,
        input  ready
    );

    modport sink (
        input  valid, command, send_count, recv_length, recv_seq, ack_seq,
               accepted_count, nack_flag, unavailable_flag, inactive_flag,
               overrun_flag, break_flag,
        output ready
    );
endinterface

/* sv/sol_ack_rsp_if.sv */
// Result channel carrying status, resend count and session counters.
interface sol_ack_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] resend_count;
    logic [3:0] send_seq;
    logic [7:0] recv_chars;

    modport source (
        output valid, status, resend_count, send_seq, recv_chars,
        input  ready
    );

    modport sink (
        input  valid, status, resend_count, send_seq, recv_chars,
        output ready
    );
endinterface

/* sv/sol_packet_ack_tracker_top.sv */
// Serial-over-LAN sequence and acknowledge tracker, one request per cycle while results drain.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  req     | in        | command, send/receive header fields, partner flags
//  rsp     | out       | status, resend_count, send_seq, recv_chars
//
// For each request the session state updates at the accepting edge and the
// result lands in the output register at that same edge.
// A new request is taken every cycle while the output register is empty or
// being drained; a stalled result holds the request channel off.
// Reset clears the session state and empties the output register.
module sol_packet_ack_tracker_top
    import sol_ack_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sol_ack_req_if.sink   req,
    sol_ack_rsp_if.source rsp
);

    logic [3:0] tx_seq_reg;
    logic [3:0] tx_seq_next;
    logic [7:0] tx_len_reg;
    logic [7:0] tx_len_next;
    logic [3:0] tx_acked_reg;
    logic [3:0] tx_acked_next;
    logic [3:0] rx_seq_reg;
    logic [3:0] rx_seq_next;
    logic [7:0] rx_len_reg;
    logic [7:0] rx_len_next;

    logic       rsp_valid_reg;
    logic [3:0] status_reg;
    logic [3:0] status_next;
    logic [7:0] resend_reg;
    logic [7:0] resend_next;
    logic [3:0] send_seq_reg;
    logic [7:0] recv_chars_reg;

    logic       req_fire;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        logic       data_bit;
        logic       retry_bit;
        logic       dup_seq;
        logic [7:0] rlen_chars;

        tx_seq_next   = tx_seq_reg;
        tx_len_next   = tx_len_reg;
        tx_acked_next = tx_acked_reg;
        rx_seq_next   = rx_seq_reg;
        rx_len_next   = rx_len_reg;
        status_next   = '0;
        resend_next   = '0;
        data_bit      = 1'b0;
        retry_bit     = 1'b0;
        dup_seq       = 1'b0;
        rlen_chars    = '0;

        case (req.command)
            CMD_SEND:
            begin
                tx_seq_next = (tx_seq_reg == SEQ_TOP) ? SEQ_FIRST : tx_seq_reg + 4'd1;
                tx_len_next = req.send_count;
            end
            CMD_RECV:
            begin
                rlen_chars  = (req.recv_length > HDR_BYTES) ?
                              req.recv_length - HDR_BYTES : 8'd0;
                rx_len_next = rlen_chars;
                data_bit    = (rlen_chars != 8'd0);
                dup_seq     = (req.recv_seq != SEQ_NONE) && (req.recv_seq == rx_seq_reg);

                // A repeated receive sequence only reports data presence.
                if (!dup_seq)
                begin
                    if (req.recv_seq != SEQ_NONE)
                    begin
                        rx_seq_next = req.recv_seq;
                    end
                    if (req.ack_seq != SEQ_NONE)
                    begin
                        if (req.ack_seq != tx_seq_reg)
                        begin
                            retry_bit = 1'b1;
                        end
                        else if (req.accepted_count < tx_len_reg &&
                                 tx_acked_reg < tx_seq_reg)
                        begin
                            resend_next = tx_len_reg - req.accepted_count;
                            retry_bit   = 1'b1;
                        end
                        tx_acked_next = req.ack_seq;
                    end
                    if (tx_seq_reg != SEQ_NONE &&
                        (req.nack_flag || req.unavailable_flag ||
                         req.inactive_flag || req.overrun_flag))
                    begin
                        retry_bit = 1'b1;
                    end
                    // Retry only stands while something sent is still unacknowledged.
                    if (retry_bit)
                    begin
                        if (tx_acked_next < tx_seq_reg)
                        begin
                            if (resend_next == 8'd0)
                            begin
                                resend_next = tx_len_reg;
                            end
                        end
                        else
                        begin
                            retry_bit = 1'b0;
                        end
                    end
                    status_next[ST_BREAK_BIT] = req.break_flag;
                end
                status_next[ST_DATA_BIT]   = data_bit;
                status_next[ST_RETRY_BIT]  = retry_bit;
                status_next[ST_UNUSED_BIT] = 1'b0;
            end
            CMD_RESET:
            begin
                tx_seq_next   = '0;
                tx_len_next   = '0;
                tx_acked_next = '0;
                rx_seq_next   = '0;
                rx_len_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_seq_reg    <= '0;
            tx_len_reg    <= '0;
            tx_acked_reg  <= '0;
            rx_seq_reg    <= '0;
            rx_len_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                tx_seq_reg   <= tx_seq_next;
                tx_len_reg   <= tx_len_next;
                tx_acked_reg <= tx_acked_next;
                rx_seq_reg   <= rx_seq_next;
                rx_len_reg   <= rx_len_next;
            end
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            status_reg     <= status_next;
            resend_reg     <= resend_next;
            send_seq_reg   <= tx_seq_next;
            recv_chars_reg <= rx_len_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.resend_count = resend_reg;
    assign rsp.send_seq     = send_seq_reg;
    assign rsp.recv_chars   = recv_chars_reg;

endmodule

/* sv/sol_ack_checker.sv */
// Port-level checker for the ack tracker, bound to the top level.
`include "sol_packet_ack_tracker_top_assert.svh"

module sol_ack_props
    import sol_ack_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_command,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [3:0] rsp_status,
    input logic [7:0] rsp_resend_count,
    input logic [3:0] rsp_send_seq,
    input logic [7:0] rsp_recv_chars
);

    logic        req_fire;
    logic        rsp_stall;
    logic [23:0] rsp_payload;

    assign req_fire    = req_valid && req_ready;
    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign rsp_payload = {rsp_status, rsp_resend_count, rsp_send_seq, rsp_recv_chars};

    // A stalled result stays valid and keeps its payload.
    `SOL_ACK_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_payload))

    // Every accepted request shows a result on the next cycle.
    `SOL_ACK_ASSERT_NEXT(a_req_to_rsp, clk, rst_n, req_fire, rsp_valid)

    // The transmit sequence never reads zero right after a send.
    `SOL_ACK_ASSERT_NEXT(a_send_seq_nonzero, clk, rst_n, req_fire && req_command == CMD_SEND, rsp_send_seq != SEQ_NONE)

    // Characters to resend only exist once something has been sent, with the unused status bit clear.
    `SOL_ACK_ASSERT_NOW(a_resend_needs_send, clk, rst_n, rsp_valid && rsp_resend_count != 8'd0, rsp_send_seq != SEQ_NONE && !rsp_status[ST_UNUSED_BIT])

endmodule

bind sol_packet_ack_tracker_top sol_ack_props u_sol_ack_props (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_command      (req.command),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_resend_count (rsp.resend_count),
    .rsp_send_seq     (rsp.send_seq),
    .rsp_recv_chars   (rsp.recv_chars)
);

/* test/sol_ack_checker.sv */
// Checker that predicts every ack tracker result and compares it with what the block returns.
module sol_ack_checker
    import sol_ack_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sol_ack_req_if      req,
    sol_ack_rsp_if      rsp,
    output int unsigned errors,
    output int unsigned compared,
    output int unsigned pending
);

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] resend;
        logic [3:0] seq;
        logic [7:0] chars;
    } outcome_t;

    // Session state as the predictor sees it.
    logic [3:0] out_seq;
    logic [7:0] out_len;
    logic [3:0] out_acked;
    logic [3:0] in_seq;
    logic [7:0] in_chars;
    logic [7:0] redo_chars;

    outcome_t    outcome_q[$];
    outcome_t    want;
    int unsigned fail_count = 0;
    int unsigned match_count = 0;
    int unsigned waiting = 0;

    assign errors   = fail_count;
    assign compared = match_count;
    assign pending  = waiting;

    task automatic flag_mismatch(input string what, input int got, input int exp_v);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp_v);
        fail_count++;
    endtask

    // Applies the request on the channel to the session state and returns its result.
    function automatic outcome_t session_outcome();
        outcome_t   o;
        logic [3:0] st;
        logic       repeated;
        o = '0;
        st = '0;
        repeated = 1'b0;
        case (req.command)
            CMD_SEND:
            begin
                out_seq = (out_seq == SEQ_TOP) ? SEQ_FIRST : out_seq + 4'd1;
                out_len = req.send_count;
            end
            CMD_RECV:
            begin
                redo_chars = '0;
                in_chars = (req.recv_length > HDR_BYTES) ? req.recv_length - HDR_BYTES : 8'd0;
                if (in_chars != 8'd0)
                    st[ST_DATA_BIT] = 1'b1;
                if (req.recv_seq != SEQ_NONE)
                begin
                    if (req.recv_seq == in_seq)
                        repeated = 1'b1;
                    else
                        in_seq = req.recv_seq;
                end
                // A repeated packet only reports its data; the ack is not looked at.
                if (!repeated)
                begin
                    if (req.ack_seq != SEQ_NONE)
                    begin
                        if (req.ack_seq != out_seq)
                            st[ST_RETRY_BIT] = 1'b1;
                        else if (req.accepted_count < out_len && out_acked < out_seq)
                        begin
                            redo_chars = out_len - req.accepted_count;
                            st[ST_RETRY_BIT] = 1'b1;
                        end
                        out_acked = req.ack_seq;
                    end
                    if (out_seq != SEQ_NONE && (req.nack_flag || req.unavailable_flag ||
                        req.inactive_flag || req.overrun_flag))
                        st[ST_RETRY_BIT] = 1'b1;
                    if (req.break_flag)
                        st[ST_BREAK_BIT] = 1'b1;
                    if (st[ST_RETRY_BIT])
                    begin
                        if (out_acked < out_seq)
                        begin
                            if (redo_chars == 8'd0)
                                redo_chars = out_len;
                        end
                        else
                            st[ST_RETRY_BIT] = 1'b0;
                    end
                end
                o.resend = redo_chars;
            end
            CMD_RESET:
            begin
                out_seq = '0;
                out_len = '0;
                out_acked = '0;
                in_seq = '0;
                in_chars = '0;
                redo_chars = '0;
            end
            default:
            begin
            end
        endcase
        o.status = st;
        o.seq = out_seq;
        o.chars = in_chars;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_seq = '0;
            out_len = '0;
            out_acked = '0;
            in_seq = '0;
            in_chars = '0;
            redo_chars = '0;
            outcome_q.delete();
            waiting = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                outcome_q.push_back(session_outcome());
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                    flag_mismatch("unrequested result status", int'(rsp.status), 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch("status", int'(rsp.status), int'(want.status));
                    if (rsp.resend_count !== want.resend)
                        flag_mismatch("resend_count", int'(rsp.resend_count),
                                      int'(want.resend));
                    if (rsp.send_seq !== want.seq)
                        flag_mismatch("send_seq", int'(rsp.send_seq), int'(want.seq));
                    if (rsp.recv_chars !== want.chars)
                        flag_mismatch("recv_chars", int'(rsp.recv_chars), int'(want.chars));
                    match_count++;
                end
            end
            waiting = outcome_q.size();
        end
    end

endmodule

/* test/testbench.sv */
// Top of the ack tracker test: clock, reset, request stimulus, result back-pressure and verdict.
module testbench;
    import sol_ack_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 380;
    localparam int unsigned CALM_ITEMS   = 40;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AFTER   = 120;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] send_count;
        logic [7:0] recv_length;
        logic [3:0] recv_seq;
        logic [3:0] ack_seq;
        logic [7:0] accepted_count;
        logic       nack_flag;
        logic       unavailable_flag;
        logic       inactive_flag;
        logic       overrun_flag;
        logic       break_flag;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sol_ack_req_if req();
    sol_ack_rsp_if rsp();

    sol_packet_ack_tracker_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    int unsigned errors;
    int unsigned compared;
    int unsigned pending;

    sol_ack_checker ack_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .errors   (errors),
        .compared (compared),
        .pending  (pending)
    );

    bit          calm = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned n_sent = 0;
    int unsigned per_cmd[4] = '{0, 0, 0, 0};
    int unsigned cycles = 0;

    // Rough picture of the session, used only to shape plausible headers.
    logic [3:0] last_tx = '0;
    logic [3:0] last_rx = '0;
    logic [7:0] last_len = '0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put(input request_t r);
        req.valid <= 1'b1;
        req.command <= r.command;
        req.send_count <= r.send_count;
        req.recv_length <= r.recv_length;
        req.recv_seq <= r.recv_seq;
        req.ack_seq <= r.ack_seq;
        req.accepted_count <= r.accepted_count;
        req.nack_flag <= r.nack_flag;
        req.unavailable_flag <= r.unavailable_flag;
        req.inactive_flag <= r.inactive_flag;
        req.overrun_flag <= r.overrun_flag;
        req.break_flag <= r.break_flag;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        n_sent++;
        per_cmd[r.command]++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    function automatic request_t sending(input logic [7:0] count);
        request_t r;
        r = '0;
        r.command = CMD_SEND;
        r.send_count = count;
        return r;
    endfunction

    // Flags are given as {nack, unavailable, inactive, overrun, break}.
    function automatic request_t header(input logic [7:0] len, input logic [3:0] rseq,
                                        input logic [3:0] aseq, input logic [7:0] acc,
                                        input logic [4:0] flags);
        request_t r;
        r = '0;
        r.command = CMD_RECV;
        r.recv_length = len;
        r.recv_seq = rseq;
        r.ack_seq = aseq;
        r.accepted_count = acc;
        {r.nack_flag, r.unavailable_flag, r.inactive_flag, r.overrun_flag, r.break_flag} = flags;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            r.command = CMD_SEND;
        else if (pick < 94)
            r.command = CMD_RECV;
        else if (pick < 97)
            r.command = CMD_RESET;
        else
            r.command = CMD_UNUSED;
        r.send_count = 8'($urandom_range(0, 255));
        r.recv_length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6))
                                                    : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.recv_seq = last_rx;
        else if (pick < 3)
            r.recv_seq = SEQ_NONE;
        else if (pick < 8)
            r.recv_seq = (last_rx == SEQ_TOP) ? SEQ_FIRST : last_rx + 4'd1;
        else
            r.recv_seq = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            r.ack_seq = last_tx;
        else if (pick < 7)
            r.ack_seq = SEQ_NONE;
        else
            r.ack_seq = 4'($urandom_range(0, 15));
        r.accepted_count = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, last_len))
                                                       : 8'($urandom_range(0, 255));
        r.nack_flag = ($urandom_range(0, 5) == 0);
        r.unavailable_flag = ($urandom_range(0, 5) == 0);
        r.inactive_flag = ($urandom_range(0, 5) == 0);
        r.overrun_flag = ($urandom_range(0, 5) == 0);
        r.break_flag = ($urandom_range(0, 5) == 0);
        if (r.command == CMD_SEND)
        begin
            last_tx = (last_tx == SEQ_TOP) ? SEQ_FIRST : last_tx + 4'd1;
            last_len = r.send_count;
        end
        else if (r.command == CMD_RESET)
        begin
            last_tx = SEQ_NONE;
            last_rx = SEQ_NONE;
            last_len = '0;
        end
        else if (r.command == CMD_RECV && r.recv_seq != SEQ_NONE)
            last_rx = r.recv_seq;
        return r;
    endfunction

    // Result side: random stalls, one long hold-off that backs the request channel up.
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && n_sent >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        request_t    r;
        int unsigned k;
        req.valid <= 1'b0;
        req.command <= CMD_SEND;
        req.send_count <= '0;
        req.recv_length <= '0;
        req.recv_seq <= '0;
        req.ack_seq <= '0;
        req.accepted_count <= '0;
        req.nack_flag <= 1'b0;
        req.unavailable_flag <= 1'b0;
        req.inactive_flag <= 1'b0;
        req.overrun_flag <= 1'b0;
        req.break_flag <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flags before any send, then the unused command code with every bit set.
        put(header(8'd255, 4'd15, SEQ_NONE, 8'd0, 5'b11111));
        r = '1;
        r.command = CMD_UNUSED;
        put(r);
        put(sending(8'd255));
        // Partial acknowledge, then the same packet again, then a short packet.
        put(header(8'd5, 4'd1, 4'd1, 8'd0, 5'b00000));
        put(header(8'd5, 4'd1, 4'd1, 8'd0, 5'b10000));
        put(header(8'd4, 4'd2, 4'd1, 8'd0, 5'b10000));
        put(sending(8'd0));
        put(header(8'd0, 4'd3, 4'd1, 8'd255, 5'b00000));
        put(header(8'd6, 4'd4, SEQ_NONE, 8'd0, 5'b01000));
        put(sending(8'd200));
        put(header(8'd100, 4'd5, 4'd3, 8'd200, 5'b00100));
        put(sending(8'd100));
        put(header(8'd255, 4'd6, SEQ_NONE, 8'd0, 5'b00010));
        // An ack number above the transmit sequence counts as already acknowledged.
        put(header(8'd200, 4'd7, 4'd15, 8'd99, 5'b00001));
        r = '1;
        r.command = CMD_RESET;
        put(r);
        put(header(8'd3, 4'd15, SEQ_NONE, 8'd255, 5'b11110));
        put(sending(8'd1));
        put(header(8'd9, SEQ_NONE, 4'd1, 8'd1, 5'b00000));
        r = '0;
        r.command = CMD_RESET;
        put(r);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k + CALM_ITEMS >= RANDOM_ITEMS)
                calm = 1'b1;
            put(random_request());
        end
        req.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d send, %0d receive, %0d session reset and %0d unused-code requests.",
                 per_cmd[CMD_SEND], per_cmd[CMD_RECV], per_cmd[CMD_RESET], per_cmd[CMD_UNUSED]);
        $display("Compared %0d results across random gaps and a %0d-cycle result stall.",
                 compared, LONG_HOLD);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
